### design/ssd_pkg.sv
// Shared types and constants for the sense segment decoder.
package ssd_pkg;

    localparam int CountWidth = 17;
    localparam int LenWidth   = 16;

    localparam logic [CountWidth-1:0] COUNT_MAX = '1;

    localparam logic [CountWidth-1:0] POS_LEN_HI = 17'd0;
    localparam logic [CountWidth-1:0] POS_LEN_LO = 17'd1;
    localparam logic [CountWidth-1:0] POS_SB0    = 17'd2;
    localparam logic [CountWidth-1:0] POS_SB1    = 17'd3;
    localparam logic [CountWidth-1:0] POS_SB2    = 17'd4;
    localparam logic [CountWidth-1:0] POS_SB3    = 17'd5;
    localparam logic [CountWidth-1:0] POS_SB12   = 17'd14;
    localparam logic [CountWidth-1:0] POS_SB13   = 17'd15;

    localparam logic [6:0] RC_FIXED_CUR  = 7'h70;
    localparam logic [6:0] RC_FIXED_DEF  = 7'h71;
    localparam logic [6:0] RC_DESC_CUR   = 7'h72;
    localparam logic [6:0] RC_DESC_DEF   = 7'h73;

    localparam logic [7:0] RC_MASK  = 8'h7f;
    localparam logic [7:0] KEY_MASK = 8'h0f;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_SHORT  = 2'd1,
        STATUS_FORMAT = 2'd2
    } status_t;

    typedef struct packed {
        logic [CountWidth-1:0] count;
        logic [LenWidth-1:0]   length;
        logic [6:0]            sb0;
        logic [7:0]            sb1;
        logic [7:0]            sb2;
        logic [7:0]            sb3;
        logic [7:0]            sb12;
        logic [7:0]            sb13;
    } fields_t;

    typedef struct packed {
        status_t    status;
        logic [6:0] resp_code;
        logic [3:0] key_nibble;
        logic [7:0] add_sense_code;
        logic [7:0] add_sense_qualifier;
    } result_t;

endpackage

### design/ssd_capture.sv
// Byte counter and capture registers for one sense segment.
module ssd_capture
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       sense_byte,
    input  logic             last_byte,
    output ssd_pkg::fields_t fields_next
);

    ssd_pkg::fields_t fields_reg;

    always_comb
    begin
        fields_next = fields_reg;
        if (fields_reg.count != ssd_pkg::COUNT_MAX)
        begin
            fields_next.count = fields_reg.count + 17'd1;
            unique case (fields_reg.count)
                ssd_pkg::POS_LEN_HI: fields_next.length[15:8] = sense_byte;
                ssd_pkg::POS_LEN_LO: fields_next.length[7:0]  = sense_byte;
                ssd_pkg::POS_SB0:    fields_next.sb0  = sense_byte[6:0];
                ssd_pkg::POS_SB1:    fields_next.sb1  = sense_byte;
                ssd_pkg::POS_SB2:    fields_next.sb2  = sense_byte;
                ssd_pkg::POS_SB3:    fields_next.sb3  = sense_byte;
                ssd_pkg::POS_SB12:   fields_next.sb12 = sense_byte;
                ssd_pkg::POS_SB13:   fields_next.sb13 = sense_byte;
                default:             fields_next.sb13 = fields_reg.sb13;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fields_reg <= '0;
        end
        else if (step)
        begin
            fields_reg <= last_byte ? '0 : fields_next;
        end
    end

endmodule

### design/ssd_decode.sv
// Format decode of the captured sense bytes into one result.
module ssd_decode
(
    input  ssd_pkg::fields_t fields,
    output ssd_pkg::result_t result
);

    logic [16:0] need;
    logic        short_seg;
    logic        fixed_fmt;
    logic        desc_fmt;

    assign need      = {1'b0, fields.length} + 17'd2;
    assign short_seg = (fields.count < 17'd2) || (fields.length == 16'd0)
                       || (fields.count < need);
    assign fixed_fmt = (fields.sb0 == ssd_pkg::RC_FIXED_CUR)
                       || (fields.sb0 == ssd_pkg::RC_FIXED_DEF);
    assign desc_fmt  = (fields.sb0 == ssd_pkg::RC_DESC_CUR)
                       || (fields.sb0 == ssd_pkg::RC_DESC_DEF);

    always_comb
    begin
        result = '0;
        if (short_seg)
        begin
            result.status = ssd_pkg::STATUS_SHORT;
        end
        else if (fixed_fmt)
        begin
            result.status    = ssd_pkg::STATUS_OK;
            result.resp_code = fields.sb0;
            if (fields.length >= 16'd3)
                result.key_nibble = 4'(fields.sb2 & ssd_pkg::KEY_MASK);
            if (fields.length >= 16'd13)
                result.add_sense_code = fields.sb12;
            if (fields.length >= 16'd14)
                result.add_sense_qualifier = fields.sb13;
        end
        else if (desc_fmt)
        begin
            result.status    = ssd_pkg::STATUS_OK;
            result.resp_code = fields.sb0;
            if (fields.length >= 16'd2)
                result.key_nibble = 4'(fields.sb1 & ssd_pkg::KEY_MASK);
            if (fields.length >= 16'd3)
                result.add_sense_code = fields.sb2;
            if (fields.length >= 16'd4)
                result.add_sense_qualifier = fields.sb3;
        end
        else
        begin
            result.status    = ssd_pkg::STATUS_FORMAT;
            result.resp_code = 7'({1'b0, fields.sb0} & ssd_pkg::RC_MASK);
        end
    end

endmodule

### design/scsi_sense_data_decoder.sv
// Top level of the sense segment decoder: input register, capture, decode, result register.
//
// Input stream: one segment byte per request on s_axis_tdata, s_axis_tlast on the
// final byte. The first two bytes are the big-endian sense length.
// Output stream: one request per segment, issued for the byte marked tlast;
// m_axis_tuser carries the status, m_axis_tdata the decoded fields.
// Timing: a byte taken is first held in the input register; it is counted and
// captured as it leaves that register, and for the final byte the result is
// registered at that same edge and shows on the output after it.
// Throughput: one byte per cycle. Only the final byte of a segment needs the
// result register; it waits in the input register while an earlier result is
// still held, and s_axis_tready drops until the receiver takes it.
// Reset: counter, captured bytes and both valid flags clear; the block takes
// a byte as soon as reset is released.
module scsi_sense_data_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] sense_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [6:0] resp_code, [10:7] key_nibble,
                                        // [18:11] add_sense_code,
                                        // [26:19] add_sense_qualifier, [31:27] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             in_advance;
    logic             in_accept;
    logic             out_valid_reg;
    logic             out_valid_next;
    ssd_pkg::result_t out_reg;
    ssd_pkg::result_t result;
    ssd_pkg::fields_t fields_next;

    assign in_advance    = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || in_advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (in_advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (in_advance && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (in_advance && in_last_reg)
            out_reg <= result;
    end

    ssd_capture u_capture
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_advance),
        .sense_byte  (in_byte_reg),
        .last_byte   (in_last_reg),
        .fields_next (fields_next)
    );

    ssd_decode u_decode
    (
        .fields (fields_next),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {5'd0, out_reg.add_sense_qualifier, out_reg.add_sense_code,
                            out_reg.key_nibble, out_reg.resp_code};

endmodule

### sim/scsi_sense_data_decoder_checker.sv
`timescale 1ns / 1ps
// Checker for the sense segment decoder: predicts each report and compares it with the output.
module scsi_sense_data_decoder_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    output int          mismatches,
    output int          outstanding,
    output int          decoded_reports,
    output int          short_reports,
    output int          format_reports
);

    logic [ssd_pkg::CountWidth-1:0] seg_count;
    logic [ssd_pkg::LenWidth-1:0]   seg_length;
    logic [6:0]                     sb0;
    logic [7:0]                     sb1;
    logic [7:0]                     sb2;
    logic [7:0]                     sb3;
    logic [7:0]                     sb12;
    logic [7:0]                     sb13;
    ssd_pkg::result_t               pending_reports[$];

    task automatic clear_segment();
        seg_count  = '0;
        seg_length = '0;
        sb0        = '0;
        sb1        = '0;
        sb2        = '0;
        sb3        = '0;
        sb12       = '0;
        sb13       = '0;
    endtask

    task automatic log_mismatch(input string what, input ssd_pkg::result_t exp,
                                input ssd_pkg::result_t act);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected status %0d rc %h key %h asc %h ascq %h",
                     $realtime, what, exp.status, exp.resp_code, exp.key_nibble,
                     exp.add_sense_code, exp.add_sense_qualifier);
            $display("    got status %0d rc %h key %h asc %h ascq %h pad %h",
                     act.status, act.resp_code, act.key_nibble, act.add_sense_code,
                     act.add_sense_qualifier, m_axis_tdata[31:27]);
        end
    endtask

    task automatic take_sense_byte(input logic [7:0] b, input logic last);
        logic [ssd_pkg::CountWidth-1:0] pos;
        ssd_pkg::result_t               rep;
        pos = seg_count;
        if (pos != ssd_pkg::COUNT_MAX)
        begin
            case (pos)
                ssd_pkg::POS_LEN_HI: seg_length[15:8] = b;
                ssd_pkg::POS_LEN_LO: seg_length[7:0] = b;
                ssd_pkg::POS_SB0:    sb0 = b[6:0];
                ssd_pkg::POS_SB1:    sb1 = b;
                ssd_pkg::POS_SB2:    sb2 = b;
                ssd_pkg::POS_SB3:    sb3 = b;
                ssd_pkg::POS_SB12:   sb12 = b;
                ssd_pkg::POS_SB13:   sb13 = b;
                default:             ;
            endcase
            seg_count = pos + 1'b1;
        end
        if (!last)
            return;
        rep = '0;
        rep.status = ssd_pkg::STATUS_OK;
        if (int'(seg_count) < 2 || seg_length == '0
            || int'(seg_count) < 2 + int'(seg_length))
        begin
            rep.status = ssd_pkg::STATUS_SHORT;
        end
        else if (sb0 == ssd_pkg::RC_FIXED_CUR || sb0 == ssd_pkg::RC_FIXED_DEF)
        begin
            rep.resp_code           = sb0;
            rep.key_nibble          = (seg_length >= 3) ? sb2[3:0] : 4'd0;
            rep.add_sense_code      = (seg_length >= 13) ? sb12 : 8'd0;
            rep.add_sense_qualifier = (seg_length >= 14) ? sb13 : 8'd0;
        end
        else if (sb0 == ssd_pkg::RC_DESC_CUR || sb0 == ssd_pkg::RC_DESC_DEF)
        begin
            rep.resp_code           = sb0;
            rep.key_nibble          = (seg_length >= 2) ? sb1[3:0] : 4'd0;
            rep.add_sense_code      = (seg_length >= 3) ? sb2 : 8'd0;
            rep.add_sense_qualifier = (seg_length >= 4) ? sb3 : 8'd0;
        end
        else
        begin
            rep.status    = ssd_pkg::STATUS_FORMAT;
            rep.resp_code = sb0;
        end
        pending_reports.push_back(rep);
        clear_segment();
    endtask

    task automatic check_report();
        ssd_pkg::result_t act;
        ssd_pkg::result_t exp;
        act.status              = ssd_pkg::status_t'(m_axis_tuser);
        act.resp_code           = m_axis_tdata[6:0];
        act.key_nibble          = m_axis_tdata[10:7];
        act.add_sense_code      = m_axis_tdata[18:11];
        act.add_sense_qualifier = m_axis_tdata[26:19];
        if (pending_reports.size() == 0)
        begin
            log_mismatch("unexpected report", '0, act);
            return;
        end
        exp = pending_reports.pop_front();
        case (exp.status)
            ssd_pkg::STATUS_OK:    decoded_reports++;
            ssd_pkg::STATUS_SHORT: short_reports++;
            default:               format_reports++;
        endcase
        if (act !== exp || m_axis_tdata[31:27] !== 5'd0)
            log_mismatch("report mismatch", exp, act);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_segment();
            pending_reports.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_report();
            if (s_axis_tvalid && s_axis_tready)
                take_sense_byte(s_axis_tdata, s_axis_tlast);
        end
        outstanding = pending_reports.size();
    end

endmodule

### sim/scsi_sense_data_decoder_test.sv
`timescale 1ns / 1ps
// Testbench top for the sense segment decoder: clock, reset, segment stimulus and verdict.
module scsi_sense_data_decoder_test;

    localparam int RandomBytes   = 1600;
    localparam int StallCycles   = 400;
    localparam int CycleLimit    = 6000000;
    localparam int SaturateBytes = 131075;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_MOSTLY,
        READY_PERIODIC
    } ready_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int          mismatches;
    int          outstanding;
    int          decoded_reports;
    int          short_reports;
    int          format_reports;

    int          cycle_count = 0;
    int          burst_left = 0;
    int          stall_asks = 0;
    int          segments_sent = 0;
    int          byte_total = 0;
    logic [7:0]  seg_bytes[$];

    scsi_sense_data_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    scsi_sense_data_decoder_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .decoded_reports (decoded_reports),
        .short_reports   (short_reports),
        .format_reports  (format_reports)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
    begin : receiver
        ready_mode_t mode;
        int          mode_left;
        int          phase;
        int          stalls_done;
        if (stalls_done != stall_asks)
        begin
            stalls_done++;
            m_axis_tready <= 1'b0;
            repeat (StallCycles) @(negedge clk);
        end
        if (mode_left == 0)
        begin
            mode = ready_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        phase++;
        case (mode)
            READY_ALWAYS:   m_axis_tready <= 1'b1;
            READY_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            READY_MOSTLY:   m_axis_tready <= ($urandom_range(0, 9) != 0);
            default:        m_axis_tready <= (phase % 5 < 2);
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 32);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        byte_total++;
        @(negedge clk);
    endtask

    task automatic send_segment();
        foreach (seg_bytes[i])
            send_byte(seg_bytes[i], i == seg_bytes.size() - 1);
        segments_sent++;
    endtask

    task automatic build_segment(input logic [15:0] len, input int nsense,
                                 input logic [7:0] rc);
        seg_bytes.delete();
        seg_bytes.push_back(len[15:8]);
        seg_bytes.push_back(len[7:0]);
        for (int i = 0; i < nsense; i++)
            seg_bytes.push_back(i == 0 ? rc : 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    task automatic send_random_segment();
        int         kind;
        int         len;
        int         nsense;
        logic [7:0] rc;
        kind = $urandom_range(0, 99);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 16);
        rc   = {1'($urandom_range(0, 1)), ssd_pkg::RC_FIXED_CUR + 7'($urandom_range(0, 3))};
        if (kind < 70)
        begin
            nsense = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            build_segment(16'(len), nsense, rc);
        end
        else if (kind < 82)
        begin
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(2, 65535);
            else
                len = $urandom_range(2, 40);
            build_segment(16'(len), $urandom_range(0, 6 < len - 1 ? 6 : len - 1), rc);
        end
        else if (kind < 92)
        begin
            do
                rc = 8'($urandom_range(0, 255));
            while (rc[6:0] == ssd_pkg::RC_FIXED_CUR || rc[6:0] == ssd_pkg::RC_FIXED_DEF
                   || rc[6:0] == ssd_pkg::RC_DESC_CUR || rc[6:0] == ssd_pkg::RC_DESC_DEF);
            build_segment(16'(len), len, rc);
        end
        else if (kind < 96)
        begin
            build_segment(16'd0, $urandom_range(0, 5), rc);
        end
        else
        begin
            seg_bytes.delete();
            repeat ($urandom_range(1, 3))
                seg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_segment();
    endtask

    initial
    begin
        int random_start;
        int seg_index;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        seg_bytes = '{8'hA5};
        send_segment();
        build_segment(16'd0, 0, 8'h00);
        send_segment();
        build_segment(16'd0, 3, 8'h70);
        send_segment();
        build_segment(16'd1, 1, 8'hF0);
        send_segment();
        build_segment(16'd18, 18, 8'h70);
        seg_bytes[4]  = 8'hFF;
        seg_bytes[14] = 8'hFF;
        seg_bytes[15] = 8'hFF;
        send_segment();
        build_segment(16'd18, 18, 8'hF0);
        seg_bytes[4]  = 8'h00;
        seg_bytes[14] = 8'h00;
        seg_bytes[15] = 8'h00;
        send_segment();
        build_segment(16'd13, 16, 8'h71);
        send_segment();
        build_segment(16'd2, 2, 8'h72);
        send_segment();
        build_segment(16'd3, 3, 8'hF2);
        send_segment();
        build_segment(16'd4, 4, 8'h73);
        seg_bytes[3] = 8'hFF;
        seg_bytes[4] = 8'hFF;
        seg_bytes[5] = 8'hFF;
        send_segment();
        build_segment(16'd8, 8, 8'h7F);
        send_segment();
        build_segment(16'd1, 1, 8'h00);
        send_segment();
        build_segment(16'd3, 3, 8'h74);
        send_segment();
        build_segment(16'd20, 10, 8'h70);
        send_segment();
        build_segment(16'hFFFF, 4, 8'h72);
        send_segment();
        build_segment(16'h0100, 256, 8'h70);
        send_segment();
        build_segment(16'hFFFF, SaturateBytes - 2, 8'hF3);
        send_segment();
        drain_reports();

        random_start = byte_total;
        seg_index = 0;
        while (byte_total - random_start < RandomBytes)
        begin
            if (seg_index == 20 || seg_index == 150)
                stall_asks++;
            if (seg_index == 80)
                drain_reports();
            send_random_segment();
            seg_index++;
        end

        s_axis_tlast  <= 1'b0;
        drain_reports();
        repeat (8) @(negedge clk);

        $display("Sent %0d segments (%0d bytes), one driving the byte counter to its limit,",
                 segments_sent, byte_total);
        $display("with long output stalls; reports checked: %0d decoded, %0d short, %0d unknown",
                 decoded_reports, short_reports, format_reports);
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
